### sv/dlsq_pkg.sv
`timescale 1ns / 1ps
package dlsq_pkg;
	localparam int MAX_IMAGES = 8;
	localparam int SLOT_W = 3;
	localparam int CNT_W = 4;

	localparam logic [2:0] REG_CX = 3'd0;
	localparam logic [2:0] REG_CY = 3'd1;
	localparam logic [2:0] REG_CZ = 3'd2;
	localparam logic [2:0] REG_RAD = 3'd3;
	localparam logic [2:0] REG_CNT = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;

	// square root radicand below 2^70, root below 2^35
	localparam int RAD_W = 70;
	localparam int ROOT_W = 36;

	typedef struct packed {
		logic [SLOT_W-1:0] image_slot;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [1:0] ray_axis;
		logic cmd;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] level_value;
		logic inside_res;
		logic [30:0] ray_distance;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load_pt;     // capture query point, clear minima
		logic sel_cent;    // select centre k (0 = base)
		logic sq_x;        // square step: dx^2
		logic sq_y;
		logic sq_z;
		logic sqrt_dist;   // start root of distance
		logic sqrt_chord;  // start root of chord
		logic fold;        // fold this centre into minima
		logic [CNT_W-1:0] k;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sqrt_busy;
	} dp_stat_t;
endpackage

### sv/dlsq_if.sv
`timescale 1ns / 1ps
interface dlsq_in_if;
	import dlsq_pkg::*;
	logic valid;
	logic ready;
	in_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dlsq_out_if;
	import dlsq_pkg::*;
	logic valid;
	logic ready;
	out_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/dlsq_sqrt.sv
`timescale 1ns / 1ps
module dlsq_sqrt import dlsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [RAD_W-1:0] radicand,
	output logic busy,
	output logic [ROOT_W-1:0] root
);
	// restoring bit-serial root: one result bit per cycle
	logic [RAD_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [RAD_W-1:0] val_q;
	logic [6:0] cnt_q;
	logic [RAD_W+1:0] trial;
	logic [RAD_W+1:0] rem_sh;

	always_comb begin
		rem_sh = {rem_q[RAD_W-1:0], val_q[RAD_W-1 -: 2]};
		trial = {{(RAD_W-ROOT_W){1'b0}}, root_q, 2'b01};
	end

	// two radicand bits per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'(RAD_W / 2);
		end else if (cnt_q != 0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			root_q <= '0;
			val_q <= radicand;
		end else if (cnt_q != 0) begin
			val_q <= {val_q[RAD_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 0);
	assign root = root_q;
endmodule

### sv/dlsq_datapath.sv
`timescale 1ns / 1ps
module dlsq_datapath import dlsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_take,
	input  in_word_t in_word,
	input  dp_cmd_t cmd,
	output dp_stat_t stat,
	output out_word_t result
);
	// configuration
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0] rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
			cz_q <= '0;
			rad_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CX: cx_q <= cfg_data;
				REG_CY: cy_q <= cfg_data;
				REG_CZ: cz_q <= cfg_data;
				REG_RAD: rad_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// image table
	logic signed [31:0] img_x [MAX_IMAGES];
	logic signed [31:0] img_y [MAX_IMAGES];
	logic signed [31:0] img_z [MAX_IMAGES];
	logic signed [31:0] ox_q, oy_q, oz_q;

	always_ff @(posedge clk) begin
		if (in_take && in_word.cmd == CMD_LOAD) begin
			img_x[in_word.image_slot] <= in_word.coord_x;
			img_y[in_word.image_slot] <= in_word.coord_y;
			img_z[in_word.image_slot] <= in_word.coord_z;
		end
		if (cmd.k != 0) begin
			ox_q <= img_x[SLOT_W'(cmd.k - 1'b1)];
			oy_q <= img_y[SLOT_W'(cmd.k - 1'b1)];
			oz_q <= img_z[SLOT_W'(cmd.k - 1'b1)];
		end else begin
			ox_q <= '0;
			oy_q <= '0;
			oz_q <= '0;
		end
	end

	// query point
	logic signed [31:0] px_q, py_q, pz_q;
	logic [1:0] axis_q;
	always_ff @(posedge clk) begin
		if (in_take && in_word.cmd == CMD_QUERY) begin
			px_q <= in_word.coord_x;
			py_q <= in_word.coord_y;
			pz_q <= in_word.coord_z;
			axis_q <= in_word.ray_axis;
		end
	end

	// centre and differences (34 bits holds p - (c + o))
	logic signed [33:0] ecx_q, ecy_q, ecz_q;
	logic signed [33:0] dx, dy, dz;
	logic [32:0] mx, my, mz;
	always_ff @(posedge clk) begin
		if (cmd.sel_cent) begin
			ecx_q <= 34'(cx_q) + 34'(ox_q);
			ecy_q <= 34'(cy_q) + 34'(oy_q);
			ecz_q <= 34'(cz_q) + 34'(oz_q);
		end
	end
	assign dx = 34'(px_q) - ecx_q;
	assign dy = 34'(py_q) - ecy_q;
	assign dz = 34'(pz_q) - ecz_q;
	assign mx = dx[33] ? 33'(-dx) : dx[32:0];
	assign my = dy[33] ? 33'(-dy) : dy[32:0];
	assign mz = dz[33] ? 33'(-dz) : dz[32:0];

	// squares: one 33x33 product per cycle, accumulated
	logic [32:0] sq_op;
	logic [65:0] sq_prod;
	logic [RAD_W-1:0] ssum_q;
	always_comb begin
		priority if (cmd.sq_x) sq_op = mx;
		else if (cmd.sq_y) sq_op = my;
		else sq_op = mz;
	end
	assign sq_prod = 66'(sq_op) * 66'(sq_op);

	logic [61:0] r2;
	assign r2 = 62'(rad_q) * 62'(rad_q);

	// across offset and chord radicand
	logic signed [33:0] off;
	logic [32:0] aoff;
	logic chord_ok_q;
	logic [65:0] aoff2_q;
	assign off = (axis_q == AXIS_X) ? dy : dx;
	assign aoff = off[33] ? 33'(-off) : off[32:0];

	always_ff @(posedge clk) begin
		if (cmd.sq_x) ssum_q <= RAD_W'(sq_prod);
		else if (cmd.sq_y || cmd.sq_z) ssum_q <= ssum_q + RAD_W'(sq_prod);
		if (cmd.sq_x) begin
			chord_ok_q <= aoff < 33'(rad_q);
			aoff2_q <= 66'(aoff) * 66'(aoff);
		end
	end

	// shared root unit; the distance root starts with the last square
	logic sq_start;
	logic [RAD_W-1:0] sq_rad;
	logic [ROOT_W-1:0] root;
	logic busy;
	logic [ROOT_W-1:0] dist_q;
	assign sq_start = cmd.sqrt_dist || cmd.sqrt_chord;
	assign sq_rad = cmd.sqrt_dist ? (ssum_q + RAD_W'(sq_prod)) :
		(chord_ok_q ? RAD_W'(66'(r2) - aoff2_q) : '0);
	dlsq_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_rad),
		.busy(busy), .root(root)
	);
	always_ff @(posedge clk) if (cmd.sqrt_chord) dist_q <= root;
	assign stat.sqrt_busy = busy;

	// per-centre values at fold (root holds chord half length)
	logic signed [37:0] lvl;
	logic ins;
	logic signed [37:0] a, ca, h, e1, e2, d1, d2;
	logic [37:0] ray;
	assign lvl = 38'(dist_q) - 38'(rad_q);
	assign ins = ssum_q <= RAD_W'(r2);
	assign a = (axis_q == AXIS_X) ? 38'(px_q) : 38'(py_q);
	assign ca = (axis_q == AXIS_X) ? 38'(ecx_q) : 38'(ecy_q);
	assign h = 38'(root);
	assign e1 = chord_ok_q ? ca + h : '0;
	assign e2 = chord_ok_q ? ca - h : '0;
	assign d1 = a - e1;
	assign d2 = a - e2;
	always_comb begin
		logic [37:0] m1, m2;
		m1 = d1[37] ? -d1 : d1;
		m2 = d2[37] ? -d2 : d2;
		ray = (axis_q == AXIS_X || axis_q == AXIS_Y) ? ((m1 < m2) ? m1 : m2) : '0;
	end

	// running minima of level and ray; inside flag is ORed
	logic signed [37:0] lvl_q;
	logic ins_q;
	logic [37:0] ray_q;
	always_ff @(posedge clk) begin
		if (cmd.fold) begin
			if (cmd.k == 0 || lvl < lvl_q) lvl_q <= lvl;
			ins_q <= (cmd.k == 0) ? ins : (ins_q | ins);
			if (cmd.k == 0 || ray < ray_q) ray_q <= ray;
		end
	end

	always_comb begin
		if (lvl_q > 38'sd2147483647) result.level_value = 32'h7fffffff;
		else if (lvl_q < -38'sd2147483648) result.level_value = 32'h80000000;
		else result.level_value = lvl_q[31:0];
		result.inside_res = ins_q;
		result.ray_distance = (ray_q > 38'h7fffffff) ? 31'h7fffffff : ray_q[30:0];
	end
endmodule

### sv/dlsq_ctrl.sv
`timescale 1ns / 1ps
module dlsq_ctrl import dlsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	input  logic in_cmd,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t cmd
);
	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SEL  = 9'b000000010,
		S_SQX  = 9'b000000100,
		S_SQY  = 9'b000001000,
		S_SQZ  = 9'b000010000,
		S_RTD  = 9'b000100000,
		S_RTC  = 9'b001000000,
		S_FOLD = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	state_t st_q;
	logic [CNT_W-1:0] k_q, n_q, cnt_cfg_q;
	logic wait_q;
	logic take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_cfg_q <= '0;
		else if (cfg_we && cfg_index == REG_CNT) cnt_cfg_q <= cfg_data[CNT_W-1:0];
	end

	assign in_ready = (st_q == S_IDLE);
	assign take = in_valid && in_ready;
	assign out_valid = (st_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			k_q <= '0;
			n_q <= '0;
			wait_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (take && in_cmd == CMD_QUERY) begin
					k_q <= '0;
					n_q <= (cnt_cfg_q > CNT_W'(MAX_IMAGES)) ? CNT_W'(MAX_IMAGES) : cnt_cfg_q;
					st_q <= S_SEL;
				end
				S_SEL: st_q <= S_SQX;
				S_SQX: st_q <= S_SQY;
				S_SQY: st_q <= S_SQZ;
				S_SQZ: begin st_q <= S_RTD; wait_q <= 1'b0; end
				// root unit: start, then wait for done
				S_RTD: if (!wait_q) wait_q <= 1'b1;
					else if (!stat.sqrt_busy) begin st_q <= S_RTC; wait_q <= 1'b0; end
				S_RTC: if (!wait_q) wait_q <= 1'b1;
					else if (!stat.sqrt_busy) begin st_q <= S_FOLD; wait_q <= 1'b0; end
				S_FOLD: if (k_q == n_q) st_q <= S_OUT;
					else begin k_q <= k_q + 1'b1; st_q <= S_SEL; end
				S_OUT: if (out_ready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// the table read address is k; hold it stable during SEL
	always_comb begin
		cmd = '0;
		cmd.k = k_q;
		cmd.load_pt = take;
		cmd.sel_cent = (st_q == S_SQX);
		cmd.sq_x = (st_q == S_SQY);
		cmd.sq_y = (st_q == S_SQZ);
		cmd.sq_z = (st_q == S_RTD) && !wait_q;
		cmd.sqrt_dist = (st_q == S_RTD) && !wait_q;
		cmd.sqrt_chord = (st_q == S_RTC) && !wait_q;
		cmd.fold = (st_q == S_FOLD);
	end
endmodule

### sv/disc_level_set_query_unit.sv
`timescale 1ns / 1ps
// A query works through n+1 centres from accept to result valid, n = images in use (up to 8).
// Each centre takes two passes through the one shared root unit.
// A new query is accepted only after the result of the last one is taken.
// Load words are written to the image table on accept. One query is worked at a time.
// Reset clears control state and configuration registers; the image table is undefined until written.
module disc_level_set_query_unit import dlsq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	dlsq_in_if.sink in_ch,
	dlsq_out_if.source out_ch
);
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic take;
	assign take = in_ch.valid && in_ch.ready;

	dlsq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_ch.valid), .in_cmd(in_ch.data.cmd),
		.in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	dlsq_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_take(take), .in_word(in_ch.data), .cmd(cmd),
		.stat(stat), .result(out_ch.data)
	);
endmodule

### bench/disc_level_set_query_unit_test.sv
`timescale 1ns / 1ps
module disc_level_set_query_unit_test;
	import dlsq_pkg::*;

	localparam logic [1:0] AXIS_NONE = 2'd2;
	localparam logic [1:0] AXIS_ODD = 2'd3;
	localparam int IDLE_LIMIT = 6000;
	localparam int DRAIN_CYCLES = 800;
	localparam int PHASES = 9;
	localparam int WORDS_PER_PHASE = 205;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		in_word_t w;
		bit typed;
		out_word_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	dlsq_in_if in_ch();
	dlsq_out_if out_ch();

	disc_level_set_query_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// shadow of the block's registers and image table
	longint cen_x, cen_y, cen_z;
	longint radius;
	int img_cnt;
	longint img_x[MAX_IMAGES], img_y[MAX_IMAGES], img_z[MAX_IMAGES];

	out_word_t level_q[$];
	int errors = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor square root of a radicand below 2^70
	function automatic logic [35:0] root_floor(input logic [71:0] v);
		logic [35:0] r;
		logic [35:0] c;
		logic [71:0] cc;
		r = '0;
		for (int b = 35; b >= 0; b--) begin
			c = r | (36'd1 << b);
			cc = {36'd0, c} * {36'd0, c};
			if (cc <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic longint abs64(input longint v);
		return v < 0 ? -v : v;
	endfunction

	// distance along the ray to the nearer chord end
	function automatic longint chord_gap(input longint a, input longint ca, input longint off);
		longint ao, h, e1, e2, d1, d2;
		logic [71:0] rad;
		ao = abs64(off);
		e1 = 0;
		e2 = 0;
		if (ao < radius) begin
			rad = 72'(radius * radius - ao * ao);
			h = longint'(root_floor(rad));
			e1 = ca + h;
			e2 = ca - h;
		end
		d1 = abs64(a - e1);
		d2 = abs64(a - e2);
		return d1 < d2 ? d1 : d2;
	endfunction

	task automatic probe_centre(input longint cx, input longint cy, input longint cz,
			input longint px, input longint py, input longint pz, input logic [1:0] axis,
			output longint lvl, output bit ins, output longint ray);
		logic [71:0] sum, dx, dy, dz, rsq;
		dx = 72'(abs64(px - cx));
		dy = 72'(abs64(py - cy));
		dz = 72'(abs64(pz - cz));
		sum = dx * dx + dy * dy + dz * dz;
		rsq = 72'(radius) * 72'(radius);
		lvl = longint'(root_floor(sum)) - radius;
		ins = sum <= rsq;
		if (axis == AXIS_X)
			ray = chord_gap(px, cx, py - cy);
		else if (axis == AXIS_Y)
			ray = chord_gap(py, cy, px - cx);
		else
			ray = 0;
	endtask

	// predicts one accepted word; loads update the image table
	task automatic predict_level(input in_word_t w, output bit has, output out_word_t res);
		longint px, py, pz, lvl, l2, ray, r2;
		bit ins, i2;
		int n;
		px = longint'(w.coord_x);
		py = longint'(w.coord_y);
		pz = longint'(w.coord_z);
		has = 1'b0;
		res = '0;
		if (w.cmd == CMD_LOAD) begin
			if (int'(w.image_slot) < MAX_IMAGES) begin
				img_x[w.image_slot] = px;
				img_y[w.image_slot] = py;
				img_z[w.image_slot] = pz;
			end
			return;
		end
		probe_centre(cen_x, cen_y, cen_z, px, py, pz, w.ray_axis, lvl, ins, ray);
		n = img_cnt < MAX_IMAGES ? img_cnt : MAX_IMAGES;
		for (int k = 0; k < n; k++) begin
			probe_centre(cen_x + img_x[k], cen_y + img_y[k], cen_z + img_z[k],
				px, py, pz, w.ray_axis, l2, i2, r2);
			if (l2 < lvl) lvl = l2;
			if (i2) ins = 1'b1;
			if (r2 < ray) ray = r2;
		end
		if (lvl > S32_MAX) lvl = S32_MAX;
		if (lvl < S32_MIN) lvl = S32_MIN;
		if (ray > S32_MAX) ray = S32_MAX;
		has = 1'b1;
		res.level_value = lvl[31:0];
		res.inside_res = ins;
		res.ray_distance = ray[30:0];
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			REG_CX: cen_x = longint'(signed'(val));
			REG_CY: cen_y = longint'(signed'(val));
			REG_CZ: cen_z = longint'(signed'(val));
			REG_RAD: radius = longint'(val[30:0]);
			REG_CNT: img_cnt = int'(val[3:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// sends one word in bursts with random gaps
	task automatic send_word(input in_word_t w, input bit typed, input out_word_t res);
		bit has;
		out_word_t p;
		if (burst_left == 0) begin
			in_ch.valid = 1'b0;
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_ch.valid = 1'b1;
		in_ch.data = w;
		do @(posedge clk); while (!in_ch.ready);
		predict_level(w, has, p);
		if (has)
			level_q.push_back(typed ? res : p);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid = 1'b0;
		while (level_q.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_coord(input longint base, input longint span);
		longint v;
		v = base + longint'($urandom_range(0, 32'(2 * span))) - span;
		return v[31:0];
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		longint span;
		int k;
		w.cmd = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_QUERY;
		w.image_slot = SLOT_W'($urandom_range(0, 7));
		w.ray_axis = ($urandom_range(0, 9) < 8) ? 2'($urandom_range(0, 1)) :
			2'($urandom_range(2, 3));
		if (w.cmd == CMD_LOAD) begin
			// offsets mostly a few radii away, now and then anything
			span = radius * 3 + 64;
			if (span > 64'sd1000000000) span = 64'sd1000000000;
			if ($urandom_range(0, 4) == 0) begin
				w.coord_x = $urandom;
				w.coord_y = $urandom;
				w.coord_z = $urandom;
			end else begin
				w.coord_x = rand_coord(0, span);
				w.coord_y = rand_coord(0, span);
				w.coord_z = rand_coord(0, span);
			end
			return w;
		end
		span = radius * 2 + 16;
		if (span > 64'sd1000000000) span = 64'sd1000000000;
		case ($urandom_range(0, 9))
			0, 1: begin
				w.coord_x = $urandom;
				w.coord_y = $urandom;
				w.coord_z = $urandom;
			end
			7, 8: begin
				k = $urandom_range(0, MAX_IMAGES - 1);
				w.coord_x = rand_coord(cen_x + img_x[k], span);
				w.coord_y = rand_coord(cen_y + img_y[k], span);
				w.coord_z = rand_coord(cen_z + img_z[k], span);
			end
			9: begin
				w.coord_x = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				w.coord_y = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				w.coord_z = $urandom_range(0, 1) ? 32'h00000000 : 32'h80000000;
			end
			default: begin
				w.coord_x = rand_coord(cen_x, span);
				w.coord_y = rand_coord(cen_y, span);
				w.coord_z = rand_coord(cen_z, span);
			end
		endcase
		return w;
	endfunction

	// receiver stall pattern: mode changes every stretch
	initial begin
		int mode;
		int stretch;
		out_ch.ready = 1'b0;
		mode = 0;
		stretch = 0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				mode = $urandom_range(0, 3);
				stretch = $urandom_range(16, 200);
			end
			stretch--;
			case (mode)
				0: out_ch.ready = 1'b1;
				1: out_ch.ready = 1'($urandom_range(0, 1));
				2: out_ch.ready = ($urandom_range(0, 4) == 0);
				default: out_ch.ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// result check against oldest expectation
	always @(posedge clk) begin
		out_word_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (level_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word level=%0d inside=%0b ray=%0d", $time,
					out_ch.data.level_value, out_ch.data.inside_res,
					out_ch.data.ray_distance);
			end else begin
				want = level_q.pop_front();
				if (out_ch.data.level_value !== want.level_value) begin
					errors++;
					$display("%0t: level_value expected %0d actual %0d", $time,
						want.level_value, out_ch.data.level_value);
				end
				if (out_ch.data.inside_res !== want.inside_res) begin
					errors++;
					$display("%0t: inside_res expected %0b actual %0b", $time,
						want.inside_res, out_ch.data.inside_res);
				end
				if (out_ch.data.ray_distance !== want.ray_distance) begin
					errors++;
					$display("%0t: ray_distance expected %0d actual %0d", $time,
						want.ray_distance, out_ch.data.ray_distance);
				end
			end
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("disc_level_set_query_unit regression: fail");
				$finish;
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		in_word_t w;
		int cnt_list[PHASES];
		logic [31:0] rad_word;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CX;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cen_x = 0;
		cen_y = 0;
		cen_z = 0;
		radius = 0;
		img_cnt = 0;
		foreach (img_x[i]) begin
			img_x[i] = 0;
			img_y[i] = 0;
			img_z[i] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (3) @(negedge clk);

		// directed rows under reset settings; no image is read yet
		row.typed = 1'b1;
		row.w = '{image_slot: 3'd0, coord_x: 0, coord_y: 0, coord_z: 0,
			ray_axis: AXIS_X, cmd: CMD_QUERY};
		row.res = '{level_value: 0, inside_res: 1'b1, ray_distance: 0};
		rows.push_back(row);
		row.w.ray_axis = AXIS_NONE;
		rows.push_back(row);
		row.typed = 1'b0;
		row.w = '{image_slot: 3'd0, coord_x: 32'h7fffffff, coord_y: 32'h7fffffff,
			coord_z: 32'h7fffffff, ray_axis: AXIS_NONE, cmd: CMD_QUERY};
		rows.push_back(row);
		row.w = '{image_slot: 3'd0, coord_x: 32'h80000000, coord_y: 32'h80000000,
			coord_z: 32'h80000000, ray_axis: AXIS_Y, cmd: CMD_QUERY};
		rows.push_back(row);
		row.w = '{image_slot: 3'd0, coord_x: 32'h80000000, coord_y: 32'h7fffffff,
			coord_z: 0, ray_axis: AXIS_ODD, cmd: CMD_QUERY};
		rows.push_back(row);
		row.w = '{image_slot: 3'd0, coord_x: 32'h7fffffff, coord_y: 32'h80000000,
			coord_z: 32'h00010000, ray_axis: AXIS_X, cmd: CMD_QUERY};
		rows.push_back(row);
		// fill every image slot, extremes at the ends
		for (int s = 0; s < MAX_IMAGES; s++) begin
			row.w.cmd = CMD_LOAD;
			row.w.image_slot = SLOT_W'(s);
			row.w.ray_axis = 2'(s % 4);
			if (s == 0) begin
				row.w.coord_x = 32'h7fffffff;
				row.w.coord_y = 32'h80000000;
				row.w.coord_z = 0;
			end else if (s == MAX_IMAGES - 1) begin
				row.w.coord_x = 32'h80000000;
				row.w.coord_y = 32'h7fffffff;
				row.w.coord_z = 32'hffffffff;
			end else begin
				row.w.coord_x = rand_coord(0, 64'sd200000);
				row.w.coord_y = rand_coord(0, 64'sd200000);
				row.w.coord_z = rand_coord(0, 64'sd200000);
			end
			rows.push_back(row);
		end
		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].res);

		// settings per phase: image counts include none, full and above the limit
		cnt_list = '{0, 8, 15, 1, 3, 9, 2, 5, 8};
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == 1) begin
				write_reg(REG_CX, 32'h7fffffff);
				write_reg(REG_CY, 32'h7fffffff);
				write_reg(REG_CZ, 32'h7fffffff);
				write_reg(REG_RAD, 32'hffffffff);
			end else if (p == 2) begin
				write_reg(REG_CX, 32'h80000000);
				write_reg(REG_CY, 32'h80000000);
				write_reg(REG_CZ, 32'h80000000);
				write_reg(REG_RAD, 32'h00000000);
			end else begin
				write_reg(REG_CX, rand_coord(0, 64'sd100000000));
				write_reg(REG_CY, rand_coord(0, 64'sd100000000));
				write_reg(REG_CZ, rand_coord(0, 64'sd100000000));
				rad_word = $urandom & ((32'd1 << $urandom_range(8, 26)) - 1);
				rad_word[31] = $urandom_range(0, 1);
				write_reg(REG_RAD, rad_word);
			end
			write_reg(REG_CNT, 32'(cnt_list[p]));
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				w = rand_word();
				send_word(w, 1'b0, '0);
			end
		end

		// drain
		in_ch.valid = 1'b0;
		while (level_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("disc_level_set_query_unit regression: pass");
		else
			$display("disc_level_set_query_unit regression: fail");
		$finish;
	end
endmodule
